// ===== rtl/lfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types, fixed-point constants and helpers for the line-following
// PD velocity block.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    // Wide signed word for products and accumulations
    typedef logic signed [69:0] wide_t;
    // Operand of the shared multiplier
    typedef logic signed [34:0] opnd_t;

    // Register indexes of the configuration port
    localparam logic [3:0] REG_YAW_GAIN     = 4'd0;
    localparam logic [3:0] REG_MAX_YAW_RATE = 4'd1;

    // Divider geometry
    localparam int DIV_NUM_W = 62;
    localparam int DIV_DEN_W = 32;

    // Q2.30 angle and unit constants
    localparam logic signed [34:0] Q30_ONE     = 35'sd1073741824;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;

    // Q16.16 constants
    localparam logic signed [19:0] PI_Q16     = 20'sd205887;
    localparam logic signed [19:0] TWO_PI_Q16 = 20'sd411775;
    localparam logic signed [34:0] KD_Q16     = 35'sd52429;
    localparam logic [20:0]        DT_MIN     = 21'd66;
    localparam wide_t              LIM33      = 70'sd4294967295;

    // Saturate a wide value to 32-bit signed
    function automatic logic signed [31:0] sat32(input wide_t v);
        logic signed [31:0] r;
        if (v > 70'sd2147483647)
            r = $signed(32'h7FFF_FFFF);
        else if (v < -70'sd2147483648)
            r = $signed(32'h8000_0000);
        else
            r = v[31:0];
        return r;
    endfunction

    // Clamp a wide value to +-(2^32-1)
    function automatic logic signed [33:0] clamp33(input wide_t v);
        logic signed [33:0] r;
        if (v > LIM33)
            r = LIM33[33:0];
        else if (v < -LIM33)
            r = 34'(-LIM33);
        else
            r = v[33:0];
        return r;
    endfunction

    // Arctangent of 2^-i in Q2.30
    function automatic logic [29:0] atan_lut(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd843314857;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043836;
            5'd3:  r = 30'd133525158;
            5'd4:  r = 30'd67021686;
            5'd5:  r = 30'd33543515;
            5'd6:  r = 30'd16775850;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194282;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048575;
            5'd11: r = 30'd524287;
            5'd12: r = 30'd262143;
            5'd13: r = 30'd131071;
            5'd14: r = 30'd65535;
            5'd15: r = 30'd32767;
            5'd16: r = 30'd16383;
            5'd17: r = 30'd8191;
            5'd18: r = 30'd4095;
            5'd19: r = 30'd2047;
            5'd20: r = 30'd1023;
            5'd21: r = 30'd511;
            5'd22: r = 30'd255;
            5'd23: r = 30'd127;
            5'd24: r = 30'd63;
            5'd25: r = 30'd31;
            5'd26: r = 30'd15;
            5'd27: r = 30'd8;
            5'd28: r = 30'd4;
            5'd29: r = 30'd2;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/lfpd_div.sv =====
// ----------------------------------------------------------------------------
// lfpd_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfpd_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lfpd_pkg::DIV_NUM_W-1:0] num,
    input  logic [lfpd_pkg::DIV_DEN_W-1:0] den,
    output logic                           done,
    output logic [lfpd_pkg::DIV_NUM_W-1:0] quo
);
    import lfpd_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 fits;
    logic [DIV_DEN_W-1:0] rem_next;

    // Shift in the next dividend bit and try one subtraction
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_NUM_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
    end

    // Iterate until all quotient bits are formed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= CNT_W'(DIV_NUM_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
                rem_reg <= rem_next;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/lfpd_sqrt.sv =====
// ----------------------------------------------------------------------------
// lfpd_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module lfpd_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_pos_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [64:0] trial;
    logic        fits;

    // Compare the remainder against the current trial value
    always_comb
    begin
        trial = {1'b0, res_reg} + {1'b0, bit_pos_reg};
        fits  = ({1'b0, v_reg} >= trial);
    end

    // Walk the bit position down two places each cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            v_reg       <= '0;
            res_reg     <= '0;
            bit_pos_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                v_reg       <= radicand;
                res_reg     <= '0;
                bit_pos_reg <= 64'h4000_0000_0000_0000;
                busy_reg    <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    v_reg   <= v_reg - trial[63:0];
                    res_reg <= (res_reg >> 1) + bit_pos_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_pos_reg <= bit_pos_reg >> 2;
                if (bit_pos_reg == 64'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ===== rtl/lfpd_cordic.sv =====
// ----------------------------------------------------------------------------
// lfpd_cordic
// Rotation-mode CORDIC: sine and cosine in Q2.30 of a Q16.16 heading,
// one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module lfpd_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [18:0] angle,
    output logic               done,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);
    import lfpd_pkg::*;

    localparam logic [4:0] LAST_ITER = 5'd29;

    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [34:0] t_reg;
    logic [4:0]         i_reg;
    logic               neg_reg;
    logic               busy_reg;
    logic               done_reg;

    logic signed [34:0] t_scaled;
    logic signed [34:0] t_wrap;
    logic signed [34:0] t_fold;
    logic               fold;
    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [34:0] step_ang;
    logic signed [33:0] x_out;
    logic signed [33:0] y_out;

    // Wrap the angle into +-pi and fold it into +-pi/2
    always_comb
    begin
        t_scaled = 35'(angle) <<< 14;
        if (t_scaled > PI_Q30)
            t_wrap = t_scaled - TWO_PI_Q30;
        else if (t_scaled < -PI_Q30)
            t_wrap = t_scaled + TWO_PI_Q30;
        else
            t_wrap = t_scaled;
        fold = 1'b1;
        if (t_wrap > HALF_PI_Q30)
            t_fold = t_wrap - PI_Q30;
        else if (t_wrap < -HALF_PI_Q30)
            t_fold = t_wrap + PI_Q30;
        else
        begin
            t_fold = t_wrap;
            fold   = 1'b0;
        end
    end

    // Shifted terms of the current micro-rotation
    always_comb
    begin
        x_sh     = x_reg >>> i_reg;
        y_sh     = y_reg >>> i_reg;
        step_ang = $signed({5'b0, atan_lut(i_reg)});
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            x_reg    <= '0;
            y_reg    <= '0;
            t_reg    <= '0;
            i_reg    <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg    <= CORDIC_K;
                y_reg    <= '0;
                t_reg    <= t_fold;
                neg_reg  <= fold;
                i_reg    <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (t_reg >= 0)
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    t_reg <= t_reg - step_ang;
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    t_reg <= t_reg + step_ang;
                end
                if (i_reg == LAST_ITER)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
        end
    end

    // Undo the fold and clamp to unit range
    always_comb
    begin
        x_out = neg_reg ? -x_reg : x_reg;
        y_out = neg_reg ? -y_reg : y_reg;
        if (x_out > 34'sd1073741824)
            cos_q30 = 32'sd1073741824;
        else if (x_out < -34'sd1073741824)
            cos_q30 = -32'sd1073741824;
        else
            cos_q30 = x_out[31:0];
        if (y_out > 34'sd1073741824)
            sin_q30 = 32'sd1073741824;
        else if (y_out < -34'sd1073741824)
            sin_q30 = -32'sd1073741824;
        else
            sin_q30 = y_out[31:0];
    end

    assign done = done_reg;

endmodule

// ===== rtl/line_following_pd_velocity_top.sv =====
// ----------------------------------------------------------------------------
// line_following_pd_velocity_top
// Straight-segment path follower: cross-track PD, along-track and altitude P,
// clamped yaw rate; position setpoint for a zero-length segment.
// ----------------------------------------------------------------------------
// One item is worked at a time. Five passes of the 62-step shared divider
// (three for the unit direction, two for the error derivative) dominate,
// with 32 square-root steps, 30 CORDIC steps and 24 passes through the
// shared 35x35 multiplier. A zero-length segment goes from the square root
// straight to the finish. in_stall is high while an item is being worked;
// the result waits in an output register, so the next item can be
// transferred while it is still pending. Configuration writes take effect
// at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module line_following_pd_velocity_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [20:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] seg_start_x,
    input  logic signed [31:0] seg_start_y,
    input  logic signed [31:0] seg_start_z,
    input  logic signed [31:0] seg_end_x,
    input  logic signed [31:0] seg_end_y,
    input  logic signed [31:0] seg_end_z,
    input  logic signed [18:0] goal_heading,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [18:0] heading_now,
    input  logic [20:0]        elapsed,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               setpoint_kind,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] out_yaw
);
    import lfpd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_DIR, S_ALONG, S_CR, S_AE,
        S_CORDIC, S_ROT, S_DD, S_KD, S_YAW, S_FIN
    } state_t;

    state_t             state_reg;
    logic [2:0]         idx_reg;
    logic               phase_reg;

    logic signed [31:0] d_reg [3];
    logic signed [31:0] rel_reg [3];
    logic signed [31:0] en_reg [3];
    logic signed [31:0] dir_reg [3];
    logic signed [33:0] cr_reg [3];
    logic signed [33:0] aed_reg [2];
    logic signed [31:0] cb_reg [2];
    logic signed [34:0] ab_reg [2];
    logic signed [43:0] dd_reg [2];
    logic signed [44:0] kd_reg [2];
    logic signed [31:0] prev_reg [2];
    logic signed [18:0] gh_reg;
    logic signed [18:0] hn_reg;
    logic [20:0]        dt_reg;
    logic [20:0]        yaw_gain_reg;
    logic [20:0]        max_yaw_rate_reg;
    logic [31:0]        len_reg;
    logic signed [33:0] along_reg;
    logic signed [33:0] ae_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] yaw_reg;
    logic               kind_reg;
    wide_t              prod_reg;
    wide_t              acc_reg;

    logic               out_valid_reg;
    logic               kind_out_reg;
    logic signed [31:0] x_out_reg;
    logic signed [31:0] y_out_reg;
    logic signed [31:0] z_out_reg;
    logic signed [31:0] yaw_out_reg;

    logic [1:0]         i3;
    logic               in_xfer;
    logic               out_free;
    logic               fin_fire;
    opnd_t              mul_a;
    opnd_t              mul_b;
    wide_t              mul_p;
    wide_t              acc_term;
    logic               acc_first;
    wide_t              acc_sum;
    wide_t              sum30;
    wide_t              prod30;
    wide_t              prod16;
    wide_t              along_w;
    wide_t              len_w;

    logic signed [31:0] d_in [3];
    logic signed [31:0] rel_in [3];
    logic [20:0]        dt_in;

    logic               sq_start;
    logic               sq_done;
    logic [31:0]        sq_root;
    logic               div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic               div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic               cor_start;
    logic               cor_done;
    logic signed [31:0] cor_cos;
    logic signed [31:0] cor_sin;

    logic signed [32:0] d_ext;
    logic signed [32:0] d_mag;
    logic signed [33:0] diff;
    logic signed [33:0] diff_mag;
    logic signed [31:0] dir_new;
    logic [30:0]        dir_mag;
    logic signed [43:0] dd_new;
    opnd_t              coef;
    opnd_t              vec;

    logic signed [19:0] dyaw_raw;
    logic signed [19:0] dyaw;
    wide_t              lim_w;
    wide_t              yaw_w;
    wide_t              vx_w;
    wide_t              vy_w;

    assign i3       = idx_reg[1:0];
    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign fin_fire = (state_reg == S_FIN) && out_free;

    // Differences to the segment start, saturated to 32 bits; elapsed raised to DT_MIN
    always_comb
    begin
        d_in[0]   = sat32(wide_t'(seg_end_x) - wide_t'(seg_start_x));
        d_in[1]   = sat32(wide_t'(seg_end_y) - wide_t'(seg_start_y));
        d_in[2]   = sat32(wide_t'(seg_end_z) - wide_t'(seg_start_z));
        rel_in[0] = sat32(wide_t'(pos_x) - wide_t'(seg_start_x));
        rel_in[1] = sat32(wide_t'(pos_y) - wide_t'(seg_start_y));
        rel_in[2] = sat32(wide_t'(pos_z) - wide_t'(seg_start_z));
        dt_in     = (elapsed < DT_MIN) ? DT_MIN : elapsed;
    end

    // Rotation coefficient and vector term for the body-frame passes
    always_comb
    begin
        if (!idx_reg[1])
            coef = idx_reg[0] ? opnd_t'(sin_reg) : opnd_t'(cos_reg);
        else
            coef = idx_reg[0] ? opnd_t'(cos_reg) : -opnd_t'(sin_reg);
        if (!idx_reg[2])
            vec = opnd_t'(cr_reg[{1'b0, idx_reg[0]}]);
        else
            vec = opnd_t'(aed_reg[idx_reg[0]]);
    end

    // Select the operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = opnd_t'(d_reg[i3]);
                mul_b = opnd_t'(d_reg[i3]);
            end
            S_ALONG:
            begin
                mul_a = opnd_t'(rel_reg[i3]);
                mul_b = opnd_t'(dir_reg[i3]);
            end
            S_CR:
            begin
                mul_a = opnd_t'(along_reg);
                mul_b = opnd_t'(dir_reg[i3]);
            end
            S_AE:
            begin
                mul_a = opnd_t'(ae_reg);
                mul_b = opnd_t'(dir_reg[i3]);
            end
            S_ROT:
            begin
                mul_a = coef;
                mul_b = vec;
            end
            S_KD:
            begin
                mul_a = KD_Q16;
                if (idx_reg[0])
                    mul_b = $signed({19'b0, dd_reg[idx_reg[1]][15:0]});
                else
                    mul_b = opnd_t'($signed(dd_reg[idx_reg[1]][43:16]));
            end
            S_YAW:
            begin
                mul_a = $signed({14'b0, yaw_gain_reg});
                mul_b = opnd_t'(dyaw);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Accumulate products; the low derivative part enters scaled down
    always_comb
    begin
        prod16    = prod_reg >>> 16;
        prod30    = prod_reg >>> 30;
        acc_term  = ((state_reg == S_KD) && idx_reg[0]) ? prod16 : prod_reg;
        case (state_reg)
            S_SQ, S_ALONG: acc_first = (idx_reg == 3'd0);
            S_ROT, S_KD:   acc_first = !idx_reg[0];
            default:       acc_first = 1'b1;
        endcase
        acc_sum = (acc_first ? '0 : acc_reg) + acc_term;
        sum30   = acc_sum >>> 30;
        len_w   = $signed({38'b0, len_reg});
        if (sum30 < 0)
            along_w = '0;
        else if (sum30 > len_w)
            along_w = len_w;
        else
            along_w = sum30;
    end

    // Divider operands and signed quotients
    always_comb
    begin
        d_ext    = 33'(d_reg[i3]);
        d_mag    = (d_ext < 0) ? -d_ext : d_ext;
        diff     = 34'(cb_reg[idx_reg[0]]) - 34'(prev_reg[idx_reg[0]]);
        diff_mag = (diff < 0) ? -diff : diff;
        if (state_reg == S_DIR)
        begin
            div_num = {d_mag[31:0], 30'b0};
            div_den = len_reg;
        end
        else
        begin
            div_num = {13'b0, diff_mag[32:0], 16'b0};
            div_den = {11'b0, dt_reg};
        end
        dir_mag = (div_quo > 62'd1073741824) ? 31'd1073741824 : div_quo[30:0];
        dir_new = d_ext[32] ? -$signed({1'b0, dir_mag}) : $signed({1'b0, dir_mag});
        dd_new  = diff[33] ? -$signed({1'b0, div_quo[42:0]})
                           : $signed({1'b0, div_quo[42:0]});
    end

    // Wrapped heading error, yaw rate clamp and body velocities
    always_comb
    begin
        dyaw_raw = 20'(gh_reg) - 20'(hn_reg);
        if (dyaw_raw > PI_Q16)
            dyaw = dyaw_raw - TWO_PI_Q16;
        else if (dyaw_raw < -PI_Q16)
            dyaw = dyaw_raw + TWO_PI_Q16;
        else
            dyaw = dyaw_raw;
        lim_w = $signed({49'b0, max_yaw_rate_reg});
        if (prod16 > lim_w)
            yaw_w = lim_w;
        else if (prod16 < -lim_w)
            yaw_w = -lim_w;
        else
            yaw_w = prod16;
        vx_w = wide_t'(ab_reg[0]) - (wide_t'(cb_reg[0]) <<< 1) - wide_t'(kd_reg[0]);
        vy_w = wide_t'(ab_reg[1]) - (wide_t'(cb_reg[1]) <<< 1) - wide_t'(kd_reg[1]);
    end

    assign sq_start  = (state_reg == S_SQRT) && !phase_reg;
    assign div_start = ((state_reg == S_DIR) || (state_reg == S_DD)) && !phase_reg;
    assign cor_start = (state_reg == S_CORDIC) && !phase_reg;

    lfpd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (acc_reg[63:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    lfpd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    lfpd_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (hn_reg),
        .done    (cor_done),
        .cos_q30 (cor_cos),
        .sin_q30 (cor_sin)
    );

    // Sequencer, working registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            phase_reg        <= 1'b0;
            yaw_gain_reg     <= 21'd65536;
            max_yaw_rate_reg <= 21'd32768;
            prev_reg[0]      <= '0;
            prev_reg[1]      <= '0;
            out_valid_reg    <= 1'b0;
            kind_reg         <= 1'b0;
        end
        else
        begin
            // Configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_YAW_GAIN:     yaw_gain_reg     <= cfg_wdata;
                    REG_MAX_YAW_RATE: max_yaw_rate_reg <= cfg_wdata;
                    default:          ;
                endcase
            end

            // Raise valid for a finished result; drop it once transferred
            if (fin_fire)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // Product register loads on the first phase of every pass
            if (!phase_reg)
                prod_reg <= mul_p;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            d_reg[k]   <= d_in[k];
                            rel_reg[k] <= rel_in[k];
                        end
                        en_reg[0] <= seg_end_x;
                        en_reg[1] <= seg_end_y;
                        en_reg[2] <= seg_end_z;
                        gh_reg    <= goal_heading;
                        hn_reg    <= heading_now;
                        dt_reg    <= dt_in;
                        kind_reg  <= 1'b0;
                        idx_reg   <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ, S_ALONG, S_ROT, S_KD:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        acc_reg   <= acc_sum;
                        phase_reg <= 1'b0;
                        case (state_reg)
                            S_SQ:
                            begin
                                idx_reg <= idx_reg + 1'b1;
                                if (idx_reg == 3'd2)
                                    state_reg <= S_SQRT;
                            end
                            S_ALONG:
                            begin
                                if (idx_reg == 3'd2)
                                begin
                                    along_reg <= along_w[33:0];
                                    ae_reg    <= 34'(len_w - along_w);
                                    idx_reg   <= '0;
                                    state_reg <= S_CR;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 1'b1;
                                end
                            end
                            S_ROT:
                            begin
                                if (idx_reg[0])
                                begin
                                    if (!idx_reg[2])
                                        cb_reg[idx_reg[1]] <= sat32(sum30);
                                    else
                                        ab_reg[idx_reg[1]] <= sum30[34:0];
                                end
                                if (idx_reg == 3'd7)
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= S_DD;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                idx_reg <= idx_reg + 1'b1;
                                if (idx_reg[0])
                                    kd_reg[idx_reg[1]] <= acc_sum[44:0];
                                if (idx_reg == 3'd3)
                                    state_reg <= S_YAW;
                            end
                        endcase
                    end
                end
                S_SQRT:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else if (sq_done)
                    begin
                        len_reg   <= sq_root;
                        phase_reg <= 1'b0;
                        idx_reg   <= '0;
                        if (sq_root == 32'd0)
                        begin
                            kind_reg  <= 1'b1;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_DIR;
                        end
                    end
                end
                S_DIR:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        dir_reg[i3] <= dir_new;
                        phase_reg   <= 1'b0;
                        if (idx_reg == 3'd2)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_ALONG;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_CR:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        cr_reg[i3] <= clamp33(wide_t'(rel_reg[i3]) - prod30);
                        if (idx_reg == 3'd2)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_AE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_AE:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        aed_reg[idx_reg[0]] <= clamp33(prod30);
                        if (idx_reg == 3'd1)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_CORDIC;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_CORDIC:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else if (cor_done)
                    begin
                        cos_reg   <= cor_cos;
                        sin_reg   <= cor_sin;
                        phase_reg <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= S_ROT;
                    end
                end
                S_DD:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        dd_reg[idx_reg[0]] <= dd_new;
                        phase_reg          <= 1'b0;
                        if (idx_reg == 3'd1)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_KD;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_YAW:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        yaw_reg   <= yaw_w[31:0];
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        kind_out_reg  <= kind_reg;
                        if (kind_reg)
                        begin
                            x_out_reg   <= en_reg[0];
                            y_out_reg   <= en_reg[1];
                            z_out_reg   <= en_reg[2];
                            yaw_out_reg <= 32'(gh_reg);
                        end
                        else
                        begin
                            x_out_reg   <= sat32(vx_w);
                            y_out_reg   <= sat32(vy_w);
                            z_out_reg   <= sat32(-wide_t'(cr_reg[2]));
                            yaw_out_reg <= yaw_reg;
                            prev_reg[0] <= cb_reg[0];
                            prev_reg[1] <= cb_reg[1];
                        end
                        phase_reg <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign setpoint_kind = kind_out_reg;
    assign out_x         = x_out_reg;
    assign out_y         = y_out_reg;
    assign out_z         = z_out_reg;
    assign out_yaw       = yaw_out_reg;

endmodule

// ===== tb/tb_line_following_pd_velocity_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_following_pd_velocity_top
// Self-checking bench for the straight-segment PD path follower. A local
// fixed-point model of projection, CORDIC rotation, PD/P terms and the yaw
// clamp predicts each setpoint at input transfer; a monitor compares every
// output transfer against the oldest prediction. Directed corner items, a
// register sweep, random phases under random idling and one long output
// hold-off are run in turn.
// ----------------------------------------------------------------------------
module tb_line_following_pd_velocity_top;
    import lfpd_pkg::*;

    localparam logic [3:0] REG_SPARE_FIRST = 4'd2;
    localparam logic [3:0] REG_SPARE_LAST  = 4'd15;
    localparam longint     ONE_Q30      = 64'sd1073741824;
    localparam longint     HALF_TURN_30 = 64'sd3373259426;
    localparam longint     QTR_TURN_30  = 64'sd1686629713;
    localparam longint     FULL_TURN_30 = 64'sd6746518852;
    localparam longint     GAIN_CORDIC  = 64'sd652032874;
    localparam longint     HALF_TURN_16 = 64'sd205887;
    localparam longint     FULL_TURN_16 = 64'sd411775;
    localparam longint     DERIV_GAIN   = 64'sd52429;
    localparam longint     MIN_STEP     = 64'sd66;
    localparam longint     ROT_LIMIT    = 64'sd4294967295;
    localparam int         CYCLE_LIMIT  = 3000000;
    localparam int         SETTLE       = 600;

    typedef struct {
        logic signed [31:0] sx, sy, sz, ex, ey, ez, px, py, pz;
        logic signed [18:0] goal, head;
        logic [20:0]        dt;
    } path_item_t;

    typedef struct {
        logic               kind;
        logic signed [31:0] x, y, z, yaw;
    } setpoint_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [3:0]         cfg_index = '0;
    logic [20:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] seg_start_x = '0, seg_start_y = '0, seg_start_z = '0;
    logic signed [31:0] seg_end_x = '0, seg_end_y = '0, seg_end_z = '0;
    logic signed [18:0] goal_heading = '0, heading_now = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [20:0]        elapsed = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               setpoint_kind;
    logic signed [31:0] out_x, out_y, out_z, out_yaw;

    // Model state and register copies
    longint    model_yaw_gain = 65536;
    longint    model_max_rate = 32768;
    longint    last_cross_fwd = 0;
    longint    last_cross_side = 0;
    longint    atan_steps[30] = '{
        843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 8, 4, 2};

    setpoint_t expected_setpoints[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        setpoints_checked = 0;
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    logic      hold_off = 1'b0;
    int        cycles = 0;

    line_following_pd_velocity_top dut (.*);

    always #4 clk = ~clk;

    // ---------------------------------------------------------------- model
    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint clip32(longint v);
        return clip(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint floor_root(bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic void heading_sincos(input longint ang, output longint c,
                                           output longint s);
        longint t, x, y, nx;
        bit     flip;
        t = ang * 16384;
        x = GAIN_CORDIC;
        y = 0;
        flip = 0;
        while (t > HALF_TURN_30) t -= FULL_TURN_30;
        while (t < -HALF_TURN_30) t += FULL_TURN_30;
        if (t > QTR_TURN_30) begin
            t -= HALF_TURN_30;
            flip = 1;
        end
        else if (t < -QTR_TURN_30) begin
            t += HALF_TURN_30;
            flip = 1;
        end
        for (int i = 0; i < 30; i++) begin
            if (t >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                t -= atan_steps[i];
            end
            else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                t += atan_steps[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clip(x, -ONE_Q30, ONE_Q30);
        s = clip(y, -ONE_Q30, ONE_Q30);
    endfunction

    function automatic longint rotate_q30(longint a, longint b, longint ka, longint kb);
        return (ka * clip(a, -ROT_LIMIT, ROT_LIMIT) + kb * clip(b, -ROT_LIMIT, ROT_LIMIT))
               >>> 30;
    endfunction

    // Predict one setpoint; advances the stored cross-track errors unless the segment has zero length
    function automatic setpoint_t predict_setpoint(path_item_t it);
        setpoint_t r;
        longint st[3], en[3], ps[3], d[3], rel[3], dir[3], cr[3];
        longint len, along, ae, c, s, cbx, cby, ax, ay, abx, aby, ddx, ddy;
        longint step, gh, hn, herr, rate;
        bit [63:0] sum;
        st = '{it.sx, it.sy, it.sz};
        en = '{it.ex, it.ey, it.ez};
        ps = '{it.px, it.py, it.pz};
        gh = it.goal;
        hn = it.head;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = clip32(en[i] - st[i]);
            rel[i] = clip32(ps[i] - st[i]);
            sum = sum + 64'(d[i] * d[i]);
        end
        len = floor_root(sum);
        if (len == 0) begin
            r.kind = 1'b1;
            r.x = 32'(en[0]);
            r.y = 32'(en[1]);
            r.z = 32'(en[2]);
            r.yaw = 32'(gh);
            return r;
        end
        along = 0;
        for (int i = 0; i < 3; i++) begin
            dir[i] = clip((d[i] * ONE_Q30) / len, -ONE_Q30, ONE_Q30);
            along += rel[i] * dir[i];
        end
        along = clip(along >>> 30, 0, len);
        for (int i = 0; i < 3; i++)
            cr[i] = clip(rel[i] - ((along * dir[i]) >>> 30), -ROT_LIMIT, ROT_LIMIT);
        ae = len - along;
        heading_sincos(hn, c, s);
        cbx = clip32(rotate_q30(cr[0], cr[1], c, s));
        cby = clip32(rotate_q30(cr[0], cr[1], -s, c));
        ax = (ae * dir[0]) >>> 30;
        ay = (ae * dir[1]) >>> 30;
        abx = rotate_q30(ax, ay, c, s);
        aby = rotate_q30(ax, ay, -s, c);
        step = it.dt;
        if (step < MIN_STEP) step = MIN_STEP;
        ddx = ((cbx - last_cross_fwd) * 65536) / step;
        ddy = ((cby - last_cross_side) * 65536) / step;
        last_cross_fwd = cbx;
        last_cross_side = cby;
        herr = gh - hn;
        while (herr > HALF_TURN_16) herr -= FULL_TURN_16;
        while (herr < -HALF_TURN_16) herr += FULL_TURN_16;
        rate = clip((model_yaw_gain * herr) >>> 16, -model_max_rate, model_max_rate);
        r.kind = 1'b0;
        r.x = 32'(clip32(-(2 * cbx + ((DERIV_GAIN * ddx) >>> 16)) + abx));
        r.y = 32'(clip32(-(2 * cby + ((DERIV_GAIN * ddy) >>> 16)) + aby));
        r.z = 32'(clip32(-cr[2]));
        r.yaw = 32'(rate);
        return r;
    endfunction

    // ------------------------------------------------------------- checking
    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d (setpoint %0d)",
                 what, got, want, setpoints_checked);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : monitor
        setpoint_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_setpoints.size() == 0) begin
                $display("MISMATCH unexpected setpoint transfer");
                mismatches++;
            end
            else begin
                want = expected_setpoints.pop_front();
                if (setpoint_kind !== want.kind)
                    report_mismatch("setpoint_kind", setpoint_kind, want.kind);
                if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
                if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
                if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
                if (out_yaw !== want.yaw) report_mismatch("out_yaw", out_yaw, want.yaw);
            end
            setpoints_checked++;
        end
    end

    // Output stall: random plus forced hold-off
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < receiver_stall_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // --------------------------------------------------------------- driving
    task automatic send_item(path_item_t it);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        seg_start_x <= it.sx; seg_start_y <= it.sy; seg_start_z <= it.sz;
        seg_end_x <= it.ex;   seg_end_y <= it.ey;   seg_end_z <= it.ez;
        pos_x <= it.px;       pos_y <= it.py;       pos_z <= it.pz;
        goal_heading <= it.goal;
        heading_now <= it.head;
        elapsed <= it.dt;
        do @(posedge clk); while (in_stall);
        expected_setpoints.push_back(predict_setpoint(it));
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_setpoints.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [20:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_YAW_GAIN) model_yaw_gain = val;
        else if (idx == REG_MAX_YAW_RATE) model_max_rate = val;
    endtask

    // ------------------------------------------------------------ stimulus
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(9))
            6, 7, 8: return $urandom;
            9: case ($urandom_range(3))
                   0: return 32'sh7FFF_FFFF;
                   1: return 32'sh8000_0000;
                   2: return 0;
                   default: return -1;
               endcase
            default: return int'($urandom_range(2097152)) - 1048576;
        endcase
    endfunction

    function automatic logic signed [18:0] rand_heading();
        if ($urandom_range(4) == 0) return 19'($urandom);
        return 19'(int'($urandom_range(411776)) - 205888);
    endfunction

    function automatic path_item_t rand_item();
        path_item_t it;
        it.sx = rand_coord(); it.sy = rand_coord(); it.sz = rand_coord();
        case ($urandom_range(11))
            0: begin it.ex = it.sx; it.ey = it.sy; it.ez = it.sz; end
            1: begin it.ex = rand_coord(); it.ey = rand_coord(); it.ez = rand_coord(); end
            default: begin
                it.ex = it.sx + int'($urandom_range(1048576)) - 524288;
                it.ey = it.sy + int'($urandom_range(1048576)) - 524288;
                it.ez = it.sz + int'($urandom_range(65536)) - 32768;
            end
        endcase
        if ($urandom_range(5) == 0) begin
            it.px = rand_coord(); it.py = rand_coord(); it.pz = rand_coord();
        end
        else begin
            it.px = it.sx + int'($urandom_range(1310720)) - 131072;
            it.py = it.sy + int'($urandom_range(1310720)) - 131072;
            it.pz = it.sz + int'($urandom_range(262144)) - 131072;
        end
        it.goal = rand_heading();
        it.head = rand_heading();
        case ($urandom_range(9))
            0: it.dt = 21'($urandom_range(70));
            1, 2, 3, 4: it.dt = 21'($urandom_range(1048576));
            default: it.dt = 21'($urandom_range(20000, 1000));
        endcase
        return it;
    endfunction

    function automatic path_item_t mk(longint sx, sy, sz, ex, ey, ez, px, py, pz,
                                      longint goal, head, dt);
        path_item_t it;
        it = '{32'(sx), 32'(sy), 32'(sz), 32'(ex), 32'(ey), 32'(ez),
               32'(px), 32'(py), 32'(pz), 19'(goal), 19'(head), 21'(dt)};
        return it;
    endfunction

    // ----------------------------------------------------------------- tests
    task automatic test_directed();
        localparam longint MX = 64'sd2147483647;
        localparam longint MN = -64'sd2147483648;
        // degenerate segments: zero, extreme, heading carried through
        send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MX, MN, MX, MX, MN, MX, 0, 0, 0, 205888, 0, 66));
        send_item(mk(MN, MN, MN, MN, MN, MN, 5, 5, 5, -205888, 0, 1));
        // along x, position alongside, behind start and past end; then a y-z segment
        send_item(mk(0, 0, 0, 655360, 0, 0, 131072, 65536, 32768, 0, 0, 6554));
        send_item(mk(0, 0, 0, 655360, 0, 0, -131072, -65536, 0, 0, 0, 65));
        send_item(mk(0, 0, 0, 655360, 0, 0, 1310720, 0, -65536, 0, 0, 66));
        send_item(mk(0, 0, 0, 0, 655360, 65536, 65536, 65536, 0, 102944, 102944, 1048576));
        // shortest non-degenerate segment
        send_item(mk(100, 100, 100, 101, 100, 100, 300, 400, 500, 0, 51472, 3277));
        // huge coordinates: saturated differences and cross errors
        send_item(mk(MN, MN, MN, MX, MX, MX, MX, MN, MX, 0, 0, 66));
        send_item(mk(MX, MX, 0, MN, MN, 0, MN, MX, MN, 0, 205888, 0));
        send_item(mk(MX, 0, 0, MN, 0, 0, MX, MX, MX, 0, -205888, 2));
        // heading at and beyond +-pi, yaw error wrap
        send_item(mk(0, 0, 0, 65536, 65536, 0, 0, 65536, 0, 205888, -205888, 6554));
        send_item(mk(0, 0, 0, 65536, 65536, 0, 0, 65536, 0, -205888, 205888, 6554));
        send_item(mk(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 262143, -262144, 6554));
        send_item(mk(0, 0, 0, 65536, 0, 0, 0, 65536, 0, -262144, 262143, 6554));
        send_item(mk(0, 0, 0, 65536, 0, 0, 0, 0, 0, 150000, -150000, 1048575));
        send_item(mk(-65536, 0, 0, 0, -65536, 0, 65536, 65536, 65536, 1000, 0, 0));
        drain();
    endtask

    task automatic test_registers();
        // extremes of both registers, then spare indexes that must be ignored
        write_reg(REG_YAW_GAIN, 21'd0);
        write_reg(REG_MAX_YAW_RATE, 21'd0);
        for (int i = 0; i < 4; i++) send_item(rand_item());
        drain();
        write_reg(REG_YAW_GAIN, 21'd1048576);
        write_reg(REG_MAX_YAW_RATE, 21'd1048576);
        for (int i = 0; i < 6; i++) send_item(rand_item());
        drain();
        write_reg(REG_SPARE_FIRST, 21'h1FFFFF);
        write_reg(REG_SPARE_LAST, 21'h0AAAAA);
        write_reg(REG_YAW_GAIN, 21'h1FFFFF);
        write_reg(REG_MAX_YAW_RATE, 21'h1FFFFF);
        for (int i = 0; i < 4; i++) send_item(rand_item());
        drain();
    endtask

    task automatic test_random_phase(int n, int idle_pct, int stall_pct);
        write_reg(REG_YAW_GAIN, 21'($urandom_range(1048576)));
        write_reg(REG_MAX_YAW_RATE, 21'($urandom_range(1048576)));
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_item(rand_item());
        drain();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_reg(REG_YAW_GAIN, 21'd65536);
        write_reg(REG_MAX_YAW_RATE, 21'd205887);
        hold_off <= 1'b1;
        fork
            begin
                repeat (4000) @(posedge clk);
                hold_off <= 1'b0;
            end
            for (int i = 0; i < 30; i++) send_item(rand_item());
        join
        drain();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_registers();
        test_random_phase(180, 0, 0);
        test_random_phase(170, 88, 0);
        test_random_phase(170, 0, 88);
        test_random_phase(170, 31, 31);
        test_backpressure();
        $display("Covered %0d path items and %0d setpoints: corners, register extremes,",
                 items_sent, setpoints_checked);
        $display("random idling phases and a long output hold-off.");
        if (mismatches == 0 && expected_setpoints.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lfpd_pkg.sv
rtl/lfpd_div.sv
rtl/lfpd_sqrt.sv
rtl/lfpd_cordic.sv
rtl/line_following_pd_velocity_top.sv
tb/tb_line_following_pd_velocity_top.sv
